// ----- design/hunt_search_lut_interpolator_top_defines.svh -----
// Assertion macros for the interpolator top level.
`ifndef HUNT_SEARCH_LUT_INTERPOLATOR_TOP_DEFINES_SVH
`define HUNT_SEARCH_LUT_INTERPOLATOR_TOP_DEFINES_SVH
// Check that an antecedent implies a consequent on the next cycle.
`define HSLI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
// Check that an expression holds at every cycle.
`define HSLI_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error(msg);
`endif

// ----- design/hsli_pkg.sv -----
// Shared types and constants for the interpolator.
`timescale 1ns / 1ps
`default_nettype none
package hsli_pkg;
	localparam int TABLE_DEPTH = 64;
	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int LEN_W = 7;
	localparam int DIV_STEPS = 64;
	localparam int CNT_W = $clog2(DIV_STEPS + 1);

	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_LOOKUP = 1'b1;

	typedef enum logic [2:0] {
		DP_NOP,
		DP_WRITE,
		DP_LOAD,
		DP_READ,
		DP_CMP,
		DP_SETUP,
		DP_MUL,
		DP_FINISH
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic div_step;
	} dp_cmd_t;

	typedef struct packed {
		logic walk_done;
		logic div_done;
	} dp_status_t;
endpackage
`default_nettype wire

// ----- design/hsli_if.sv -----
// Valid/ready channel interfaces for requests and results.
`timescale 1ns / 1ps
`default_nettype none
interface hsli_req_if;
	logic valid;
	logic ready;
	logic req_type;
	logic [5:0] entry_index;
	logic signed [31:0] entry_left;
	logic signed [31:0] entry_right;
	logic signed [31:0] lookup_key;
	modport source (output valid, req_type, entry_index, entry_left, entry_right, lookup_key,
		input ready);
	modport sink (input valid, req_type, entry_index, entry_left, entry_right, lookup_key,
		output ready);
endinterface

interface hsli_res_if;
	logic valid;
	logic ready;
	logic signed [31:0] interp_value;
	logic [5:0] segment_index;
	logic degenerate;
	logic saturated;
	modport source (output valid, interp_value, segment_index, degenerate, saturated,
		input ready);
	modport sink (input valid, interp_value, segment_index, degenerate, saturated,
		output ready);
endinterface
`default_nettype wire

// ----- design/hsli_datapath.sv -----
// Table memory, hunt walk registers, multiplier and restoring divider.
`timescale 1ns / 1ps
`default_nettype none
module hsli_datapath (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire hsli_pkg::dp_cmd_t cmd,
	output hsli_pkg::dp_status_t status,
	input  wire logic [6:0] table_length,
	input  wire logic req_type,
	input  wire logic [5:0] entry_index,
	input  wire logic [31:0] entry_left,
	input  wire logic [31:0] entry_right,
	input  wire logic [31:0] lookup_key,
	output logic [31:0] interp_value,
	output logic [5:0] segment_index,
	output logic degenerate,
	output logic saturated
);
	import hsli_pkg::*;

	logic [31:0] left_mem [TABLE_DEPTH];
	logic [31:0] right_mem [TABLE_DEPTH];
	logic [31:0] rd_left_q, rd_right_q;
	logic [IDX_W-1:0] rd_addr;

	logic [IDX_W-1:0] last_q, b_q, e_q, probe_q;
	logic [1:0] dir_q; // 0 first check b, 1 walking down, 2 check e, 3 walking up
	logic [31:0] key_q, lb_q, le_q, rb_q, re_q;
	logic [IDX_W-1:0] lmax;
	logic deg_q, dneg_q;
	logic [63:0] rem_q;
	logic [63:0] mag_q, quo_q;
	logic [31:0] dlmag_q;
	logic [CNT_W-1:0] cnt_q;
	logic walk_done_q;

	always_comb begin
		if (table_length < 7'd2) lmax = IDX_W'(1);
		else if (table_length > LEN_W'(TABLE_DEPTH)) lmax = IDX_W'(TABLE_DEPTH - 1);
		else lmax = IDX_W'(table_length - 7'd1);
	end

	assign rd_addr = probe_q;

	always_ff @(posedge clk) begin
		if (cmd.op == DP_WRITE && req_type == REQ_WRITE) begin
			left_mem[entry_index] <= entry_left;
			right_mem[entry_index] <= entry_right;
		end
		rd_left_q <= left_mem[rd_addr];
		rd_right_q <= right_mem[rd_addr];
	end

	logic signed [31:0] diff;
	assign diff = $signed(key_q - rd_left_q);

	logic signed [32:0] dr;
	logic signed [31:0] dl, dx;
	assign dr = $signed({re_q[31], re_q}) - $signed({rb_q[31], rb_q});
	assign dl = $signed(le_q - lb_q);
	assign dx = $signed(key_q - lb_q);

	logic signed [64:0] prod;
	assign prod = 65'(dx) * 65'(dr);

	logic [64:0] trial;
	assign trial = {rem_q, mag_q[63]} - {33'd0, dlmag_q};

	logic signed [33:0] mean_sum;
	assign mean_sum = $signed({{2{rb_q[31]}}, rb_q}) + $signed({{2{re_q[31]}}, re_q});

	logic signed [64:0] q_s, res_full;
	assign q_s = dneg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
	assign res_full = q_s + $signed({{33{rb_q[31]}}, rb_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= '0;
			walk_done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			unique case (cmd.op)
				DP_LOAD: begin
					key_q <= lookup_key;
					b_q <= (last_q > lmax - IDX_W'(1)) ? lmax - IDX_W'(1) : last_q;
					probe_q <= (last_q > lmax - IDX_W'(1)) ? lmax - IDX_W'(1) : last_q;
					dir_q <= 2'd0;
					walk_done_q <= 1'b0;
				end
				DP_CMP: begin
					// on the final probe, leave probe_q on the lower entry
					unique case (dir_q)
						2'd0: begin
							if (diff < 0 && b_q != '0) begin
								dir_q <= 2'd1;
								b_q <= b_q - IDX_W'(1);
								probe_q <= b_q - IDX_W'(1);
							end else if (diff < 0) begin
								walk_done_q <= 1'b1;
								e_q <= b_q + IDX_W'(1);
							end else begin
								dir_q <= 2'd2;
								e_q <= b_q + IDX_W'(1);
								probe_q <= b_q + IDX_W'(1);
							end
						end
						2'd1: begin
							if (diff >= 0 || b_q == '0) begin
								walk_done_q <= 1'b1;
								e_q <= b_q + IDX_W'(1);
							end else begin
								b_q <= b_q - IDX_W'(1);
								probe_q <= b_q - IDX_W'(1);
							end
						end
						2'd2: begin
							if (diff > 0 && e_q != lmax) begin
								dir_q <= 2'd3;
								e_q <= e_q + IDX_W'(1);
								probe_q <= e_q + IDX_W'(1);
							end else begin
								walk_done_q <= 1'b1;
								b_q <= e_q - IDX_W'(1);
								probe_q <= e_q - IDX_W'(1);
							end
						end
						default: begin
							if (diff <= 0 || e_q == lmax) begin
								walk_done_q <= 1'b1;
								b_q <= e_q - IDX_W'(1);
								probe_q <= e_q - IDX_W'(1);
							end else begin
								e_q <= e_q + IDX_W'(1);
								probe_q <= e_q + IDX_W'(1);
							end
						end
					endcase
				end
				DP_READ: begin
					// lower entry data arrives; point at upper entry
					lb_q <= rd_left_q;
					rb_q <= rd_right_q;
					probe_q <= e_q;
					last_q <= b_q;
				end
				DP_SETUP: begin
					le_q <= rd_left_q;
					re_q <= rd_right_q;
				end
				DP_MUL: begin
					deg_q <= (dl == 0);
					dneg_q <= dx[31] ^ dr[32] ^ dl[31];
					mag_q <= prod[64] ? 64'(-prod) : 64'(prod);
					dlmag_q <= dl[31] ? 32'(-dl) : 32'(dl);
					rem_q <= '0;
					quo_q <= '0;
					cnt_q <= CNT_W'(DIV_STEPS);
				end
				default: ;
			endcase
			if (cmd.div_step && cnt_q != '0) begin
				mag_q <= {mag_q[62:0], 1'b0};
				if (!trial[64]) begin
					rem_q <= trial[63:0];
					quo_q <= {quo_q[62:0], 1'b1};
				end else begin
					rem_q <= {rem_q[62:0], mag_q[63]};
					quo_q <= {quo_q[62:0], 1'b0};
				end
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == DP_WRITE) begin
			interp_value <= '0;
			segment_index <= '0;
			degenerate <= 1'b0;
			saturated <= 1'b0;
		end else if (cmd.op == DP_FINISH) begin
			segment_index <= b_q;
			degenerate <= deg_q;
			if (deg_q) begin
				interp_value <= 32'((mean_sum + (mean_sum < 0 ? 34'sd1 : 34'sd0)) >>> 1);
				saturated <= 1'b0;
			end else if (res_full > 65'sh7FFFFFFF) begin
				interp_value <= 32'h7FFFFFFF;
				saturated <= 1'b1;
			end else if (res_full < -65'sh80000000) begin
				interp_value <= 32'h80000000;
				saturated <= 1'b1;
			end else begin
				interp_value <= res_full[31:0];
				saturated <= 1'b0;
			end
		end
	end

	assign status.walk_done = walk_done_q;
	assign status.div_done = (cnt_q == '0);
endmodule
`default_nettype wire

// ----- design/hsli_ctrl.sv -----
// Sequencer for write, hunt walk, divide and result handoff.
`timescale 1ns / 1ps
`default_nettype none
module hsli_ctrl (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	input  wire logic in_req_type,
	output logic in_ready,
	output logic out_valid,
	input  wire logic out_ready,
	output hsli_pkg::dp_cmd_t cmd,
	input  wire hsli_pkg::dp_status_t status
);
	import hsli_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_FETCH, S_CMP, S_LOW, S_HIGH, S_MUL, S_DIV, S_FIN, S_OUT
	} state_t;
	state_t state_q;
	logic wait_q;

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);

	always_comb begin
		cmd.op = DP_NOP;
		cmd.div_step = (state_q == S_DIV);
		unique case (state_q)
			S_IDLE: if (in_valid) cmd.op = (in_req_type == REQ_LOOKUP) ? DP_LOAD : DP_WRITE;
			S_CMP: if (!wait_q && !status.walk_done) cmd.op = DP_CMP;
			S_LOW: cmd.op = DP_READ;
			S_HIGH: cmd.op = DP_SETUP;
			S_MUL: cmd.op = DP_MUL;
			S_FIN: cmd.op = DP_FINISH;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			wait_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: if (in_valid) begin
					state_q <= (in_req_type == REQ_LOOKUP) ? S_FETCH : S_OUT;
				end
				S_FETCH: begin
					state_q <= S_CMP;
					wait_q <= 1'b1;
				end
				S_CMP: begin
					// alternate: wait for the registered table read, then compare
					if (wait_q) wait_q <= 1'b0;
					else if (status.walk_done) begin
						wait_q <= 1'b1;
						state_q <= S_LOW;
					end else wait_q <= 1'b1;
				end
				S_LOW: begin
					if (wait_q) wait_q <= 1'b0;
					else state_q <= S_HIGH;
				end
				S_HIGH: state_q <= S_MUL;
				S_MUL: state_q <= S_DIV;
				S_DIV: if (status.div_done) state_q <= S_FIN;
				S_FIN: state_q <= S_OUT;
				S_OUT: if (out_ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ----- design/hunt_search_lut_interpolator_top.sv -----
// Hunt-search table interpolator: one transaction in, one result out.
// A write gives its result in the next cycle; lookup time is set by the registered table
// read per walk probe and by the 64-step shift-subtract divider.
// Throughput: one transaction at a time; a new one is taken after the result is taken.
// Reset (arst_n low, asynchronous): idle, remembered segment 0, length 64;
// table contents stay undefined until written.
`timescale 1ns / 1ps
`default_nettype none
`include "hunt_search_lut_interpolator_top_defines.svh"
module hunt_search_lut_interpolator_top (
	input  wire logic clk,
	input  wire logic arst_n,
	hsli_req_if.sink req,
	hsli_res_if.source res,
	input  wire logic cfg_we,
	input  wire logic [6:0] cfg_wdata
);
	import hsli_pkg::*;

	logic [LEN_W-1:0] table_length_q;
	dp_cmd_t cmd;
	dp_status_t status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) table_length_q <= LEN_W'(64);
		else if (cfg_we) table_length_q <= cfg_wdata;
	end

	hsli_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(req.valid), .in_req_type(req.req_type), .in_ready(req.ready),
		.out_valid(res.valid), .out_ready(res.ready),
		.cmd(cmd), .status(status)
	);

	hsli_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .status(status),
		.table_length(table_length_q),
		.req_type(req.req_type), .entry_index(req.entry_index),
		.entry_left(req.entry_left), .entry_right(req.entry_right),
		.lookup_key(req.lookup_key),
		.interp_value(res.interp_value), .segment_index(res.segment_index),
		.degenerate(res.degenerate), .saturated(res.saturated)
	);

	`HSLI_ASSERT_ALWAYS(a_no_both, clk, arst_n, !(req.ready && res.valid), "ready while busy")
	`HSLI_ASSERT_NEXT(a_write_out, clk, arst_n, req.valid && req.ready && !req.req_type, res.valid, "no write result")
	`HSLI_ASSERT_ALWAYS(a_flags, clk, arst_n, !(res.valid && res.degenerate && res.saturated), "both flags")
endmodule
`default_nettype wire

// ----- bench/tb_hunt_search_lut_interpolator_top.sv -----
// Testbench for the hunt-search table interpolator: predicts and checks every result.
`timescale 1ns / 1ps
module tb_hunt_search_lut_interpolator_top;
	import hsli_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [6:0] cfg_wdata = '0;

	hsli_req_if req ();
	hsli_res_if res ();

	hunt_search_lut_interpolator_top dut (
		.clk(clk), .arst_n(arst_n), .req(req.sink), .res(res.source),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	typedef struct packed {
		logic signed [31:0] value;
		logic [5:0] seg;
		logic deg;
		logic sat;
	} interp_t;

	// predictor state
	logic [31:0] pl_left [TABLE_DEPTH];
	logic [31:0] pl_right [TABLE_DEPTH];
	logic [5:0] pl_last_seg;
	logic [6:0] pl_len;

	interp_t expected_q[$];
	int errors = 0;
	int n_lookups = 0;
	int n_writes = 0;
	int n_deg = 0;
	int n_sat = 0;
	longint cycles = 0;
	bit quiet = 1'b0;
	int max_gap = 15;

	function automatic int eff_len();
		int l;
		l = pl_len;
		if (l < 2) l = 2;
		if (l > TABLE_DEPTH) l = TABLE_DEPTH;
		return l;
	endfunction

	function automatic logic signed [31:0] wdiff(logic [31:0] a, logic [31:0] b);
		return $signed(a - b);
	endfunction

	function automatic interp_t interpolate(logic [31:0] key);
		interp_t r;
		int l, b, e;
		longint br, er, dl, dx, sum;
		l = eff_len();
		b = pl_last_seg;
		if (b > l - 2) b = l - 2;
		e = b + 1;
		if (wdiff(key, pl_left[b]) < 0) begin
			while (b != 0) begin
				b--;
				if (wdiff(key, pl_left[b]) >= 0) break;
			end
			e = b + 1;
		end else if (wdiff(key, pl_left[e]) > 0) begin
			while (e != l - 1) begin
				e++;
				if (wdiff(key, pl_left[e]) <= 0) break;
			end
			b = e - 1;
		end
		pl_last_seg = b[5:0];
		br = $signed(pl_right[b]);
		er = $signed(pl_right[e]);
		dl = wdiff(pl_left[e], pl_left[b]);
		r = '0;
		r.seg = b[5:0];
		if (dl == 0) begin
			r.deg = 1'b1;
			sum = (br + er) / 2;
		end else begin
			dx = wdiff(key, pl_left[b]);
			sum = br + (dx * (er - br)) / dl;
			if (sum > 64'sd2147483647) begin
				sum = 64'sd2147483647;
				r.sat = 1'b1;
			end
			if (sum < -64'sd2147483648) begin
				sum = -64'sd2147483648;
				r.sat = 1'b1;
			end
		end
		r.value = sum[31:0];
		return r;
	endfunction

	task automatic report(string what, logic [63:0] got, logic [63:0] want);
		errors++;
		$display("MISMATCH %s: got %0h expected %0h at cycle %0d", what, got, want, cycles);
	endtask

	task automatic idle_burst();
		if (!quiet && $urandom_range(0, 3) == 0) begin
			req.valid <= 1'b0;
			repeat ($urandom_range(1, max_gap)) @(posedge clk);
		end
	endtask

	task automatic send(logic rt, logic [5:0] idx, logic [31:0] lft, logic [31:0] rgt,
		logic [31:0] key);
		interp_t r;
		idle_burst();
		req.valid <= 1'b1;
		req.req_type <= rt;
		req.entry_index <= idx;
		req.entry_left <= lft;
		req.entry_right <= rgt;
		req.lookup_key <= key;
		do @(posedge clk); while (!req.ready);
		// valid drops in the next idle burst or drain
		if (rt == REQ_WRITE) begin
			pl_left[idx] = lft;
			pl_right[idx] = rgt;
			expected_q.push_back('0);
			n_writes++;
		end else begin
			r = interpolate(key);
			if (r.deg) n_deg++;
			if (r.sat) n_sat++;
			expected_q.push_back(r);
			n_lookups++;
		end
	endtask

	task automatic drain();
		req.valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_length(logic [6:0] v);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		pl_len = v;
		@(posedge clk);
	endtask

	task automatic lookup(logic [31:0] key);
		send(REQ_LOOKUP, 6'($urandom), $urandom, $urandom, key);
	endtask

	task automatic write_entry(int i, logic [31:0] lft, logic [31:0] rgt);
		send(REQ_WRITE, i[5:0], lft, rgt, $urandom);
	endtask

	// fill all entries with an ascending table and random outputs
	task automatic load_sorted(int step);
		for (int i = 0; i < TABLE_DEPTH; i++)
			write_entry(i, (i - 32) * step, $urandom);
	endtask

	// sink side: random stalls, check each result against the oldest prediction
	always @(posedge clk) begin
		interp_t w;
		cycles <= cycles + 1;
		if (arst_n && res.valid && res.ready) begin
			if (expected_q.size() == 0) begin
				report("unexpected result", res.interp_value, 0);
			end else begin
				w = expected_q.pop_front();
				if (res.interp_value !== w.value) report("interp_value", res.interp_value, w.value);
				if (res.segment_index !== w.seg) report("segment_index", res.segment_index, w.seg);
				if (res.degenerate !== w.deg) report("degenerate", res.degenerate, w.deg);
				if (res.saturated !== w.sat) report("saturated", res.saturated, w.sat);
			end
		end
	end

	initial begin
		res.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!quiet && $urandom_range(0, 7) == 0) begin
				res.ready <= 1'b0;
				repeat ($urandom_range(1, 15)) @(posedge clk);
			end
			res.ready <= 1'b1;
		end
	end

	initial begin
		@(posedge clk);
		while (cycles < 64'd3000000) @(posedge clk);
		$display("Timeout after %0d cycles", cycles);
		$display("Test completed with failures");
		$finish;
	end

	task automatic test_edges();
		load_sorted(1000);
		lookup(32'sh80000000);
		lookup(32'sh7fffffff);
		lookup(0);
		lookup(-32000);
		lookup(31000);
		lookup(500);
		lookup(-1);
		// extreme outputs on one segment to force clipping
		write_entry(0, -100, 32'sh7fffffff);
		write_entry(1, -99, 32'sh80000000);
		lookup(32'sh80000000);
		lookup(32'sh7fffffff);
		// equal breakpoints give the mean, but key 5000 ends the hunt on segment 9
		write_entry(10, 5000, 32'sh7fffffff);
		write_entry(11, 5000, 32'sh7ffffffd);
		lookup(5000);
		write_entry(11, 5000, 32'sh80000000);
		lookup(5000);
		write_entry(63, 32'sh7fffffff, 32'sh80000000);
		lookup(32'sh7ffffff0);
	endtask

	task automatic test_length_settings();
		logic [6:0] lens [6] = '{7'd0, 7'd1, 7'd2, 7'd127, 7'd65, 7'd64};
		load_sorted(777);
		foreach (lens[k]) begin
			set_length(lens[k]);
			lookup(32'sh7fffffff);
			lookup(32'sh80000000);
			lookup($urandom);
		end
		// shrink so the remembered segment is stale
		lookup(32'sh7fffffff);
		set_length(7'd5);
		lookup(0);
		set_length(7'd64);
	endtask

	task automatic test_random(int n);
		int step;
		for (int i = 0; i < n; i++) begin
			if (i % 300 == 0) begin
				set_length(7'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(2, 64)));
				step = $urandom_range(1, 8) == 1 ? $urandom : $urandom_range(1, 1 << 20);
			end
			if (i == n / 2) drain();
			if (i > n * 3 / 4) quiet = 1'b1;
			case ($urandom_range(0, 9))
				0: write_entry($urandom_range(0, 63), $urandom, $urandom);
				1: write_entry($urandom_range(0, 63), ($urandom_range(0, 63) - 32) * step,
					$urandom);
				2: lookup($urandom);
				default: lookup(($urandom_range(0, 70) - 35) * step + $urandom_range(0, step));
			endcase
		end
	endtask

	initial begin
		pl_len = 7'd64;
		pl_last_seg = '0;
		req.valid = 1'b0;
		req.req_type = REQ_WRITE;
		req.entry_index = '0;
		req.entry_left = '0;
		req.entry_right = '0;
		req.lookup_key = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_edges();
		test_length_settings();
		load_sorted(4096);
		test_random(1620);
		drain();
		repeat (200) @(posedge clk);
		$display("Covered %0d table writes and %0d lookups (%0d mean, %0d clipped).",
			n_writes, n_lookups, n_deg, n_sat);
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule

// ----- sim.f -----
+incdir+design
design/hsli_pkg.sv
design/hsli_if.sv
design/hsli_datapath.sv
design/hsli_ctrl.sv
design/hunt_search_lut_interpolator_top.sv
bench/tb_hunt_search_lut_interpolator_top.sv
